// ===== hw/rtl/gcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, fixed-point constants and helpers for the great-circle
// distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int DIST_FRAC_BITS  = 8;

    localparam int LAT_W    = 24;
    localparam int LON_W    = 25;
    localparam int DIST_W   = 23;
    localparam int RADIUS_W = 21;
    localparam int RATIO_W  = 16;
    localparam int CFG_W    = 21;

    // Q30 widths: unsigned magnitude, CORDIC datapath, angle accumulator
    localparam int Q30_W  = 31;
    localparam int CORD_W = 34;
    localparam int ANG_W  = 33;

    localparam int ROT_STEPS  = 30;
    localparam int ROOT_STEPS = 31;
    localparam int RAD_W      = 2 * ROOT_STEPS;
    localparam int REM_W      = ROOT_STEPS + 2;

    localparam int PIPE_DEPTH = 3 + (ROT_STEPS + 1) + 3 + (ROOT_STEPS + 1)
                              + (ROT_STEPS + 1) + 4;

    localparam logic [31:0] ONE_Q30     = 32'd1073741824;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] GAIN_Q30    = 32'd652032874;
    localparam logic [30:0] DEG_RAD_Q36 = 31'd1199381129;

    localparam int DEG_MUL_W = 56;
    localparam int SH_FULL   = ANGLE_FRAC_BITS + 6;
    localparam int SH_HALF   = ANGLE_FRAC_BITS + 7;
    localparam int KM_SH     = 30 - DIST_FRAC_BITS;
    localparam int NM_SH     = 24;

    localparam logic signed [LAT_W-1:0] LAT_LIM = LAT_W'(90 <<< ANGLE_FRAC_BITS);
    localparam logic signed [LON_W-1:0] LON_LIM = LON_W'(180 <<< ANGLE_FRAC_BITS);
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [0:0] CFG_EARTH_RADIUS = 1'b0;
    localparam logic [0:0] CFG_KM_TO_NM     = 1'b1;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 21'd1630976;
    localparam logic [RATIO_W-1:0]  RATIO_RST  = 16'd35387;

    localparam logic [31:0] ARC_HEAD [10] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149
    };

    function automatic logic signed [ANG_W-1:0] arc_of(input int i);
        logic [31:0] v;
        if (i < 10) begin
            v = ARC_HEAD[i];
        end else begin
            v = 32'd1 << (30 - i);
        end
        return $signed({1'b0, v});
    endfunction

    function automatic logic signed [LAT_W-1:0] clamp_lat(input logic signed [LAT_W-1:0] v);
        if (v > LAT_LIM) return LAT_LIM;
        if (v < -LAT_LIM) return -LAT_LIM;
        return v;
    endfunction

    function automatic logic signed [LON_W-1:0] clamp_lon(input logic signed [LON_W-1:0] v);
        if (v > LON_LIM) return LON_LIM;
        if (v < -LON_LIM) return -LON_LIM;
        return v;
    endfunction

    // clamp a CORDIC value to [0, 1.0] in Q30
    function automatic logic [Q30_W-1:0] clamp_unit(input logic signed [CORD_W-1:0] v);
        if (v < 0) return '0;
        if (v > $signed({2'b0, ONE_Q30})) return Q30_W'(ONE_Q30);
        return Q30_W'(v);
    endfunction

    function automatic logic [Q30_W-1:0] clamp_half_pi(input logic [ANG_W-1:0] r);
        if (r > ANG_W'(HALF_PI_Q30)) return Q30_W'(HALF_PI_Q30);
        return Q30_W'(r);
    endfunction

    // fold an angle above pi/2 back for the sine
    function automatic logic [Q30_W-1:0] fold_sin(input logic [ANG_W-1:0] r);
        if (r <= ANG_W'(HALF_PI_Q30)) return Q30_W'(r);
        if (r >= ANG_W'(PI_Q30)) return '0;
        return Q30_W'(ANG_W'(PI_Q30) - r);
    endfunction

endpackage

// ===== hw/rtl/gcd_pos_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pos_if
// Position-pair channel: two latitude/longitude points per transfer.
// ----------------------------------------------------------------------------
interface gcd_pos_if import gcd_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] first_latitude;
    logic signed [LON_W-1:0] first_longitude;
    logic signed [LAT_W-1:0] second_latitude;
    logic signed [LON_W-1:0] second_longitude;

    modport source (
        output valid, first_latitude, first_longitude, second_latitude, second_longitude,
        input  ready
    );
    modport sink (
        input  valid, first_latitude, first_longitude, second_latitude, second_longitude,
        output ready
    );
endinterface

// ===== hw/rtl/gcd_dist_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_dist_if
// Distance result channel.
// ----------------------------------------------------------------------------
interface gcd_dist_if import gcd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink (input valid, distance, output ready);
endinterface

// ===== hw/rtl/gcd_rot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_rot
// Pipelined rotation CORDIC, one stage per step: cosine and sine of an
// angle in [0, pi/2], Q30.
// ----------------------------------------------------------------------------
module gcd_rot import gcd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [Q30_W-1:0] i_angle,
    output logic [Q30_W-1:0] o_cos,
    output logic [Q30_W-1:0] o_sin
);

    logic signed [CORD_W-1:0] r_x [0:ROT_STEPS];
    logic signed [CORD_W-1:0] r_y [0:ROT_STEPS];
    logic signed [ANG_W-1:0]  r_z [0:ROT_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= $signed(CORD_W'(GAIN_Q30));
            r_y[0] <= '0;
            r_z[0] <= $signed(ANG_W'(i_angle));
        end
    end

    for (genvar k = 0; k < ROT_STEPS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][ANG_W-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - arc_of(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + arc_of(k);
                end
            end
        end
    end

    assign o_cos = clamp_unit(r_x[ROT_STEPS]);
    assign o_sin = clamp_unit(r_y[ROT_STEPS]);

endmodule

// ===== hw/rtl/gcd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_sqrt
// Pipelined integer floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gcd_sqrt import gcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [RAD_W-1:0]      i_radicand,
    output logic [ROOT_STEPS-1:0] o_root
);

    logic [RAD_W-1:0]      r_v    [0:ROOT_STEPS];
    logic [REM_W-1:0]      r_rem  [0:ROOT_STEPS];
    logic [ROOT_STEPS-1:0] r_root [0:ROOT_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]    <= i_radicand;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        logic [REM_W+1:0] rem2;
        logic [REM_W+1:0] trial;
        assign rem2  = {r_rem[k], r_v[k][RAD_W-1 -: 2]};
        assign trial = {2'b00, r_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k+1] <= r_v[k] << 2;
                if (rem2 >= trial) begin
                    r_rem[k+1]  <= REM_W'(rem2 - trial);
                    r_root[k+1] <= {r_root[k][ROOT_STEPS-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= REM_W'(rem2);
                    r_root[k+1] <= {r_root[k][ROOT_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[ROOT_STEPS];

endmodule

// ===== hw/rtl/gcd_vec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_vec
// Pipelined vectoring CORDIC: angle of (x, y) in the first quadrant, Q30.
// ----------------------------------------------------------------------------
module gcd_vec import gcd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [Q30_W-1:0] i_y,
    input  logic [Q30_W-1:0] i_x,
    output logic [Q30_W-1:0] o_angle
);

    logic signed [CORD_W-1:0] r_x [0:ROT_STEPS];
    logic signed [CORD_W-1:0] r_y [0:ROT_STEPS];
    logic signed [ANG_W-1:0]  r_z [0:ROT_STEPS];
    logic signed [ANG_W-1:0]  z_end;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= $signed(CORD_W'(i_x));
            r_y[0] <= $signed(CORD_W'(i_y));
            r_z[0] <= '0;
        end
    end

    for (genvar k = 0; k < ROT_STEPS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[k][CORD_W-1]) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + arc_of(k);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - arc_of(k);
                end
            end
        end
    end

    assign z_end   = r_z[ROT_STEPS];
    assign o_angle = z_end[ANG_W-1] ? '0 : clamp_half_pi(ANG_W'(z_end));

endmodule

// ===== hw/rtl/great_circle_distance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_core
// Haversine great-circle distance between two positions, in nautical miles.
// ----------------------------------------------------------------------------
// Usage:
//   i_pos carries two positions (degrees, 16 fraction bits) per transfer;
//   out-of-range coordinates are clamped. o_dist returns one distance per
//   position pair, unsigned with 8 fraction bits, in input order.
//   i_cfg_we/i_cfg_idx/i_cfg_data write the Earth radius (index 0) and the
//   km-to-nautical-mile ratio (index 1); write them only while idle.
//   Throughput: one transfer per cycle while o_dist is not stalled. Results
//   pass through the two 30-step CORDIC pipelines and the 31-step square
//   root pipeline plus ten multiply/round stages.
//   Reset clears every stage valid bit and loads the default radius and
//   ratio. When the receiver stalls with a result waiting, the whole
//   pipeline holds and i_pos.ready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module great_circle_distance_core import gcd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    gcd_pos_if.sink             i_pos,
    gcd_dist_if.source          o_dist,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    logic [RADIUS_W-1:0]   r_earth_radius;
    logic [RATIO_W-1:0]    r_km_to_nm;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earth_radius <= RADIUS_RST;
            r_km_to_nm     <= RATIO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EARTH_RADIUS: r_earth_radius <= i_cfg_data[RADIUS_W-1:0];
                CFG_KM_TO_NM:     r_km_to_nm     <= i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv         = !r_vld[PIPE_DEPTH-1] || o_dist.ready;
    assign i_pos.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_pos.valid};
        end
    end

    // stage 1: clamp, differences, magnitudes
    logic signed [LAT_W-1:0] lat1, lat2;
    logic signed [LON_W-1:0] lon1, lon2;
    logic signed [LAT_W:0]   dlat;
    logic signed [LON_W:0]   dlon;
    logic [LAT_W-1:0]        r_mag_dlat;
    logic [LON_W-1:0]        r_mag_dlon;
    logic [LAT_W-2:0]        r_mag_lat1, r_mag_lat2;

    assign lat1 = clamp_lat(i_pos.first_latitude);
    assign lat2 = clamp_lat(i_pos.second_latitude);
    assign lon1 = clamp_lon(i_pos.first_longitude);
    assign lon2 = clamp_lon(i_pos.second_longitude);
    assign dlat = {lat2[LAT_W-1], lat2} - {lat1[LAT_W-1], lat1};
    assign dlon = {lon2[LON_W-1], lon2} - {lon1[LON_W-1], lon1};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mag_dlat <= LAT_W'(dlat[LAT_W] ? -dlat : dlat);
            r_mag_dlon <= LON_W'(dlon[LON_W] ? -dlon : dlon);
            r_mag_lat1 <= (LAT_W-1)'(lat1[LAT_W-1] ? -lat1 : lat1);
            r_mag_lat2 <= (LAT_W-1)'(lat2[LAT_W-1] ? -lat2 : lat2);
        end
    end

    // stage 2: degrees to radians products
    logic [DEG_MUL_W-1:0] r_p_dlat, r_p_dlon, r_p_lat1, r_p_lat2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_dlat <= DEG_MUL_W'(r_mag_dlat) * DEG_MUL_W'(DEG_RAD_Q36);
            r_p_dlon <= DEG_MUL_W'(r_mag_dlon) * DEG_MUL_W'(DEG_RAD_Q36);
            r_p_lat1 <= DEG_MUL_W'(r_mag_lat1) * DEG_MUL_W'(DEG_RAD_Q36);
            r_p_lat2 <= DEG_MUL_W'(r_mag_lat2) * DEG_MUL_W'(DEG_RAD_Q36);
        end
    end

    // stage 3: round to Q30 radians, fold and clamp for the CORDIC
    localparam logic [DEG_MUL_W-1:0] RND_HALF = DEG_MUL_W'(1) << (SH_HALF - 1);
    localparam logic [DEG_MUL_W-1:0] RND_FULL = DEG_MUL_W'(1) << (SH_FULL - 1);

    logic [Q30_W-1:0] r_ang_dlat, r_ang_dlon, r_ang_lat1, r_ang_lat2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ang_dlat <= fold_sin(ANG_W'((r_p_dlat + RND_HALF) >> SH_HALF));
            r_ang_dlon <= fold_sin(ANG_W'((r_p_dlon + RND_HALF) >> SH_HALF));
            r_ang_lat1 <= clamp_half_pi(ANG_W'((r_p_lat1 + RND_FULL) >> SH_FULL));
            r_ang_lat2 <= clamp_half_pi(ANG_W'((r_p_lat2 + RND_FULL) >> SH_FULL));
        end
    end

    // sine and cosine
    logic [Q30_W-1:0] sin_dlat, sin_dlon, cos_lat1, cos_lat2;
    logic [Q30_W-1:0] unused_cos_dlat, unused_cos_dlon, unused_sin_lat1, unused_sin_lat2;

    gcd_rot u_rot_dlat (.i_clk, .i_en(adv), .i_angle(r_ang_dlat),
                        .o_cos(unused_cos_dlat), .o_sin(sin_dlat));
    gcd_rot u_rot_dlon (.i_clk, .i_en(adv), .i_angle(r_ang_dlon),
                        .o_cos(unused_cos_dlon), .o_sin(sin_dlon));
    gcd_rot u_rot_lat1 (.i_clk, .i_en(adv), .i_angle(r_ang_lat1),
                        .o_cos(cos_lat1), .o_sin(unused_sin_lat1));
    gcd_rot u_rot_lat2 (.i_clk, .i_en(adv), .i_angle(r_ang_lat2),
                        .o_cos(cos_lat2), .o_sin(unused_sin_lat2));

    // haversine term a
    localparam int P_W = 2 * Q30_W;
    localparam logic [P_W-1:0] RND_Q30 = P_W'(1) << 29;

    logic [P_W-1:0]   r_p_sq_lat, r_p_sq_lon, r_p_cc;
    logic [P_W-1:0]   r_p_term;
    logic [Q30_W-1:0] r_sq_lat;
    logic [Q30_W-1:0] r_a;
    logic [Q30_W:0]   a_sum;

    assign a_sum = {1'b0, r_sq_lat} + (Q30_W+1)'((r_p_term + RND_Q30) >> 30);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_sq_lat <= P_W'(sin_dlat) * P_W'(sin_dlat);
            r_p_sq_lon <= P_W'(sin_dlon) * P_W'(sin_dlon);
            r_p_cc     <= P_W'(cos_lat1) * P_W'(cos_lat2);
            r_sq_lat   <= Q30_W'((r_p_sq_lat + RND_Q30) >> 30);
            r_p_term   <= P_W'(Q30_W'((r_p_cc + RND_Q30) >> 30))
                        * P_W'(Q30_W'((r_p_sq_lon + RND_Q30) >> 30));
            r_a        <= (a_sum > (Q30_W+1)'(ONE_Q30)) ? Q30_W'(ONE_Q30) : Q30_W'(a_sum);
        end
    end

    // square roots and arctangent
    logic [ROOT_STEPS-1:0] root_y, root_x;
    logic [Q30_W-1:0]      one_minus_a;
    logic [Q30_W-1:0]      half_c;

    assign one_minus_a = Q30_W'(ONE_Q30) - r_a;

    gcd_sqrt u_sqrt_y (.i_clk, .i_en(adv), .i_radicand({1'b0, r_a, 30'd0}),
                       .o_root(root_y));
    gcd_sqrt u_sqrt_x (.i_clk, .i_en(adv), .i_radicand({1'b0, one_minus_a, 30'd0}),
                       .o_root(root_x));

    gcd_vec u_vec (.i_clk, .i_en(adv), .i_y(Q30_W'(root_y)), .i_x(Q30_W'(root_x)),
                   .o_angle(half_c));

    // scale to nautical miles
    localparam int KMP_W = RADIUS_W + Q30_W + 1;
    localparam int NMP_W = 32 + RATIO_W;
    localparam logic [KMP_W-1:0] RND_KM = KMP_W'(1) << (KM_SH - 1);
    localparam logic [NMP_W-1:0] RND_NM = NMP_W'(1) << (NM_SH - 1);

    logic [KMP_W-1:0]      r_p_km;
    logic [31:0]           r_km;
    logic [NMP_W-1:0]      r_p_nm;
    logic [NMP_W-NM_SH:0]  nm;
    logic [DIST_W-1:0]     r_dist;

    assign nm = (NMP_W-NM_SH+1)'((r_p_nm + RND_NM) >> NM_SH);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_km <= KMP_W'(r_earth_radius) * KMP_W'({half_c, 1'b0});
            r_km   <= 32'((r_p_km + RND_KM) >> KM_SH);
            r_p_nm <= NMP_W'(r_km) * NMP_W'(r_km_to_nm);
            r_dist <= (nm > (NMP_W-NM_SH+1)'(DIST_MAX)) ? DIST_MAX : DIST_W'(nm);
        end
    end

    assign o_dist.valid    = r_vld[PIPE_DEPTH-1];
    assign o_dist.distance = r_dist;

    // checks
    a_rst_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_dist.valid)
        else $error("output valid after reset");
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dist.valid && !o_dist.ready |-> !i_pos.ready)
        else $error("input taken while output stalled");
    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline moved during stall");
    a_take_moves_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pos.valid && i_pos.ready |=> r_vld[0])
        else $error("accepted item lost at first stage");

endmodule
